[src/mvi_pkg.sv]
// ----------------------------------------------------------------------------
// mvi_pkg
// Shared types and constants of the mesh volume integral engine: the
// command and status groups between controller and datapath, operand
// selects, term kinds and the divisors of the per-face scaling.
// ----------------------------------------------------------------------------
package mvi_pkg;

  localparam int SUM_W   = 64;
  localparam int SKIP_W  = 16;
  localparam int N_SUMS  = 10;
  localparam int OUT_W   = N_SUMS * SUM_W + SKIP_W;
  localparam int DIV_W   = 8;

  // Divisors of the exact face numerators (the factor two of the cubic
  // integrals is folded into the second and product divisors).
  localparam logic [DIV_W-1:0] DIV_VOL    = 8'd6;
  localparam logic [DIV_W-1:0] DIV_FIRST  = 8'd24;
  localparam logic [DIV_W-1:0] DIV_SECOND = 8'd180;
  localparam logic [DIV_W-1:0] DIV_PROD   = 8'd120;

  // Slot of each term kind in the sum bank, per axis added on top.
  localparam logic [3:0] BASE_VOL    = 4'd0;
  localparam logic [3:0] BASE_FIRST  = 4'd1;
  localparam logic [3:0] BASE_SECOND = 4'd4;
  localparam logic [3:0] BASE_PROD   = 4'd7;

  typedef enum logic [1:0] {A_COORD, A_QCOORD, A_EDGE1, A_ONE} asel_t;
  typedef enum logic [2:0] {B_COORD, B_PPLUS, B_EDGE2, B_QUAD, B_TVAL} bsel_t;
  typedef enum logic [1:0] {D_NONE, D_NRM, D_QUAD, D_TVAL} dest_t;
  typedef enum logic [1:0] {T_VOL, T_FIRST, T_SECOND, T_PROD} term_t;

  typedef struct packed {
    logic       load;
    asel_t      asel;
    logic [1:0] aidx;
    bsel_t      bsel;
    logic [1:0] bidx;
    logic [1:0] axis;
    logic       mac_en;
    logic       mac_clr;
    logic       mac_neg;
    dest_t      dest;
    logic       scale_go;
    term_t      term;
    logic       skip_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic scale_busy;
    logic scale_done;
  } stat_t;

  // Next axis in cyclic order x, y, z.
  function automatic logic [1:0] nxt3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

[src/mvi_scale.sv]
// ----------------------------------------------------------------------------
// mvi_scale
// Multi-cycle scaling unit: round(nrm * num * 2^FRAC_BITS / div) with ties
// away from zero, saturated to signed 64 bits. Two partial products, then
// a radix-256 restoring division by the small divisor.
// ----------------------------------------------------------------------------
module mvi_scale #(
  parameter int NRM_W     = 27,
  parameter int NUM_W     = 43,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic signed [NRM_W-1:0]         nrm,
  input  logic signed [NUM_W-1:0]         num,
  input  logic [mvi_pkg::DIV_W-1:0]       div,
  output logic                            busy,
  output logic                            done,
  output logic signed [mvi_pkg::SUM_W-1:0] res
);
  import mvi_pkg::*;

  localparam int H      = (NUM_W + 1) / 2;
  localparam int LO_W   = NRM_W + H;
  localparam int PROD_W = NRM_W + 2 * H;
  localparam int NEED   = PROD_W + FRAC_BITS + 1;
  localparam int DW     = (((NEED > SUM_W) ? NEED : SUM_W + 1) + 7) / 8 * 8;
  localparam int DSTEPS = DW / 8;
  localparam int CNT_W  = (DSTEPS > 1) ? $clog2(DSTEPS) : 1;

  typedef enum logic [2:0] {SC_IDLE, SC_MLO, SC_MHI, SC_SUM, SC_DIV, SC_SAT} phase_t;

  phase_t             phase_r;
  logic               neg_r;
  logic [NRM_W-1:0]   nmag_r;
  logic [2*H-1:0]     qmag_r;
  logic [LO_W-1:0]    plo_r;
  logic [LO_W-1:0]    phi_r;
  logic [DW-1:0]      dvd_r;
  logic [DW-1:0]      dvd_nxt;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   rem_nxt;
  logic [DIV_W-1:0]   div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DW-1:0]      prod_w;
  logic               big;

  assign busy = (phase_r != SC_IDLE);
  assign done = (phase_r == SC_SAT);

  // Eight quotient bits per cycle; the remainder always stays below div.
  always_comb begin
    logic [DIV_W:0]   t;
    logic             ge;
    logic [DW-1:0]    q;
    logic [DIV_W-1:0] r;
    q = dvd_r;
    r = rem_r;
    for (int i = 0; i < 8; i++) begin
      t  = {r, q[DW-1]};
      ge = (t >= {1'b0, div_r});
      q  = {q[DW-2:0], ge};
      r  = ge ? DIV_W'(t - {1'b0, div_r}) : t[DIV_W-1:0];
    end
    dvd_nxt = q;
    rem_nxt = r;
  end

  // Rejoin the two partial products into the full magnitude.
  assign prod_w = (DW'(phi_r) << H) + DW'(plo_r);

  // Saturate the quotient magnitude and apply the sign.
  assign big = |dvd_r[DW-1:SUM_W-1];
  always_comb begin
    if (neg_r) begin
      res = big ? {1'b1, {(SUM_W-1){1'b0}}} : -$signed(dvd_r[SUM_W-1:0]);
    end else begin
      res = big ? {1'b0, {(SUM_W-1){1'b1}}} : $signed(dvd_r[SUM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SC_IDLE;
    end else begin
      unique case (phase_r)
        SC_IDLE: begin
          if (go) begin
            neg_r   <= nrm[NRM_W-1] ^ num[NUM_W-1];
            nmag_r  <= nrm[NRM_W-1] ? NRM_W'(-nrm) : NRM_W'(nrm);
            qmag_r  <= num[NUM_W-1] ? (2*H)'(-(NUM_W+1)'(num))
                                    : (2*H)'(num);
            div_r   <= div;
            phase_r <= SC_MLO;
          end
        end
        SC_MLO: begin
          plo_r   <= LO_W'(nmag_r * qmag_r[H-1:0]);
          phase_r <= SC_MHI;
        end
        SC_MHI: begin
          phi_r   <= LO_W'(nmag_r * qmag_r[2*H-1:H]);
          phase_r <= SC_SUM;
        end
        SC_SUM: begin
          dvd_r   <= (prod_w << FRAC_BITS) + DW'(div_r >> 1);
          rem_r   <= '0;
          cnt_r   <= '0;
          phase_r <= SC_DIV;
        end
        SC_DIV: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DSTEPS - 1)) begin
            phase_r <= SC_SAT;
          end
        end
        SC_SAT: begin
          phase_r <= SC_IDLE;
        end
        default: phase_r <= SC_IDLE;
      endcase
    end
  end

endmodule

[src/mvi_dp.sv]
// ----------------------------------------------------------------------------
// mvi_dp
// Datapath: vertex registers, edge and sum logic, one shared multiply-
// accumulate unit with its small result file, the scaling unit and the
// bank of saturating sums with the output register.
// ----------------------------------------------------------------------------
module mvi_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mvi_pkg::cmd_t                           cmd,
  output mvi_pkg::stat_t                          stat,
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]       in_tdata,
  output logic [mvi_pkg::OUT_W-1:0]               out_tdata
);
  import mvi_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int E_W   = CB + 1;
  localparam int P_W   = CB + 2;
  localparam int A_W   = CB + 1;
  localparam int B_W   = 2 * CB + 3;
  localparam int NRM_W = 2 * CB + 3;
  localparam int ACC_W = 3 * CB + 7;

  logic signed [CB-1:0]    coord_r [9];
  logic signed [E_W-1:0]   e1 [3];
  logic signed [E_W-1:0]   e2 [3];
  logic signed [P_W-1:0]   psum [3];
  logic signed [NRM_W-1:0] nrm_r [3];
  logic signed [B_W-1:0]   t_r [3];
  logic signed [B_W-1:0]   quad_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [A_W-1:0]   opa;
  logic signed [B_W-1:0]   opb;
  logic signed [A_W+B_W-1:0] prod;
  logic [1:0]              qax;
  logic signed [SUM_W-1:0] sums_r [N_SUMS];
  logic [SKIP_W-1:0]       skip_r;
  logic [3:0]              tgt_r;
  logic [3:0]              tgt_nxt;
  logic signed [ACC_W-1:0] snum;
  logic [DIV_W-1:0]        sdiv;
  logic signed [SUM_W-1:0] sres;
  logic signed [SUM_W:0]   add_w;
  logic signed [SUM_W-1:0] add_sat;
  logic                    sbusy;
  logic                    sdone;

  function automatic logic [3:0] cidx(input logic [1:0] v, input logic [1:0] a);
    return {2'b00, v} * 4'd3 + {2'b00, a};
  endfunction

  // Edge vectors and per-axis coordinate sums of the stored face.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e1[a]   = E_W'(coord_r[3+a]) - E_W'(coord_r[a]);
      e2[a]   = E_W'(coord_r[6+a]) - E_W'(coord_r[a]);
      psum[a] = P_W'(coord_r[a]) + P_W'(coord_r[3+a]) + P_W'(coord_r[6+a]);
    end
  end

  assign qax = nxt3(cmd.axis);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.asel)
      A_COORD:  opa = A_W'(coord_r[cidx(cmd.aidx, cmd.axis)]);
      A_QCOORD: opa = A_W'(coord_r[cidx(cmd.aidx, qax)]);
      A_EDGE1:  opa = A_W'(e1[cmd.aidx]);
      default:  opa = A_W'(1);
    endcase
    case (cmd.bsel)
      B_COORD:  opb = B_W'(coord_r[cidx(cmd.bidx, cmd.axis)]);
      B_PPLUS:  opb = B_W'(coord_r[cidx(cmd.bidx, cmd.axis)]) + B_W'(psum[cmd.axis]);
      B_EDGE2:  opb = B_W'(e2[cmd.bidx]);
      B_QUAD:   opb = quad_r;
      B_TVAL:   opb = t_r[cmd.bidx];
      default:  opb = '0;
    endcase
  end

  // Multiply-accumulate.
  assign prod    = opa * opb;
  assign acc_nxt = (cmd.mac_clr ? ACC_W'(0) : acc_r)
                 + (cmd.mac_neg ? -ACC_W'(prod) : ACC_W'(prod));

  // Scaling operands per term kind.
  always_comb begin
    snum = acc_r;
    unique case (cmd.term)
      T_VOL: begin
        snum    = ACC_W'(psum[0]);
        sdiv    = DIV_VOL;
        tgt_nxt = BASE_VOL;
      end
      T_FIRST: begin
        sdiv    = DIV_FIRST;
        tgt_nxt = BASE_FIRST + {2'b00, cmd.axis};
      end
      T_SECOND: begin
        sdiv    = DIV_SECOND;
        tgt_nxt = BASE_SECOND + {2'b00, cmd.axis};
      end
      T_PROD: begin
        sdiv    = DIV_PROD;
        tgt_nxt = BASE_PROD + {2'b00, cmd.axis};
      end
      default: begin
        sdiv    = DIV_VOL;
        tgt_nxt = BASE_VOL;
      end
    endcase
  end

  mvi_scale #(
    .NRM_W     (NRM_W),
    .NUM_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.scale_go),
    .nrm   (nrm_r[cmd.axis]),
    .num   (snum),
    .div   (sdiv),
    .busy  (sbusy),
    .done  (sdone),
    .res   (sres)
  );

  // Saturating add of a scaled term into its sum.
  always_comb begin
    add_w = (SUM_W+1)'(sums_r[tgt_r]) + (SUM_W+1)'(sres);
    if (add_w[SUM_W] != add_w[SUM_W-1]) begin
      add_sat = add_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      add_sat = add_w[SUM_W-1:0];
    end
  end

  assign stat.degen      = (nrm_r[0] == '0) && (nrm_r[1] == '0) && (nrm_r[2] == '0);
  assign stat.scale_busy = sbusy;
  assign stat.scale_done = sdone;

  // Face registers and the multiply-accumulate result file.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 9; i++) begin
        coord_r[i] <= in_tdata[i*CB +: CB];
      end
    end
    if (cmd.mac_en) begin
      acc_r <= acc_nxt;
      case (cmd.dest)
        D_NRM:   nrm_r[cmd.axis] <= NRM_W'(acc_nxt);
        D_QUAD:  quad_r          <= B_W'(acc_nxt);
        D_TVAL:  t_r[cmd.aidx]   <= B_W'(acc_nxt);
        default: ;
      endcase
    end
    if (cmd.scale_go) begin
      tgt_r <= tgt_nxt;
    end
  end

  // Sum bank and skip counter; both restart from zero when the output register loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_SUMS; i++) begin
        sums_r[i] <= '0;
      end
      skip_r <= '0;
    end else begin
      if (sdone) begin
        sums_r[tgt_r] <= add_sat;
      end
      if (cmd.skip_inc && (skip_r != '1)) begin
        skip_r <= skip_r + 1'b1;
      end
      if (cmd.out_load) begin
        for (int i = 0; i < N_SUMS; i++) begin
          sums_r[i] <= '0;
        end
        skip_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < N_SUMS; i++) begin
        out_tdata[i*SUM_W +: SUM_W] <= sums_r[i];
      end
      out_tdata[N_SUMS*SUM_W +: SKIP_W] <= skip_r;
    end
  end

endmodule

[src/mvi_ctrl.sv]
// ----------------------------------------------------------------------------
// mvi_ctrl
// Controller: accepts a face, sequences the multiply-accumulate program
// for the normal and the three axes, launches the scaling of each term
// and hands the finished mesh result to the output register.
// ----------------------------------------------------------------------------
module mvi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  input  logic           out_tready,
  output logic           out_tvalid,
  output mvi_pkg::cmd_t  cmd,
  input  mvi_pkg::stat_t stat
);
  import mvi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NRM, S_CHK, S_QUAD, S_TVAL, S_SEC, S_PRD,
    S_GO, S_SCALE, S_NEXT, S_FIN
  } state_t;

  state_t     state_r;
  state_t     ret_r;
  term_t      term_r;
  logic [2:0] step_r;
  logic [1:0] axis_r;
  logic       last_r;
  logic       out_valid_r;
  logic [1:0] n;
  logic [1:0] k;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign n          = step_r[2:1];
  assign k          = (step_r < 3'd3) ? step_r[1:0] : 2'(step_r - 3'd3);

  // Command decode of the current program step.
  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    cmd.term = term_r;
    unique case (state_r) inside
      S_IDLE: cmd.load = in_tvalid;
      S_NRM: begin
        cmd.mac_en = 1'b1;
        cmd.axis   = n;
        cmd.asel   = A_EDGE1;
        cmd.bsel   = B_EDGE2;
        if (!step_r[0]) begin
          cmd.aidx    = nxt3(n);
          cmd.bidx    = nxt3(nxt3(n));
          cmd.mac_clr = 1'b1;
        end else begin
          cmd.aidx    = nxt3(nxt3(n));
          cmd.bidx    = nxt3(n);
          cmd.mac_neg = 1'b1;
          cmd.dest    = D_NRM;
        end
      end
      S_CHK: cmd.skip_inc = stat.degen;
      S_QUAD: begin
        cmd.mac_en  = 1'b1;
        cmd.asel    = A_COORD;
        cmd.bsel    = B_COORD;
        cmd.aidx    = k;
        cmd.bidx    = (step_r < 3'd3) ? k : nxt3(k);
        cmd.mac_clr = (step_r == 3'd0);
        cmd.dest    = (step_r == 3'd5) ? D_QUAD : D_NONE;
      end
      S_TVAL: begin
        cmd.mac_en = 1'b1;
        cmd.aidx   = n;
        cmd.bidx   = n;
        if (!step_r[0]) begin
          cmd.asel    = A_COORD;
          cmd.bsel    = B_PPLUS;
          cmd.mac_clr = 1'b1;
        end else begin
          cmd.asel = A_ONE;
          cmd.bsel = B_QUAD;
          cmd.dest = D_TVAL;
        end
      end
      S_SEC, S_PRD: begin
        cmd.mac_en  = 1'b1;
        cmd.asel    = (state_r == S_SEC) ? A_COORD : A_QCOORD;
        cmd.bsel    = B_TVAL;
        cmd.aidx    = step_r[1:0];
        cmd.bidx    = step_r[1:0];
        cmd.mac_clr = (step_r == 3'd0);
      end
      S_GO:    cmd.scale_go = 1'b1;
      S_FIN:   cmd.out_load = last_r && (!out_valid_r || out_tready);
      default: ;
    endcase
  end

  // State, counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      axis_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ret_r       <= S_IDLE;
      term_r      <= T_VOL;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            last_r  <= in_tlast;
            step_r  <= '0;
            axis_r  <= '0;
            state_r <= S_NRM;
          end
        end
        S_NRM: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          step_r  <= '0;
          term_r  <= T_VOL;
          ret_r   <= S_QUAD;
          state_r <= stat.degen ? S_FIN : S_GO;
        end
        S_QUAD: begin
          if (step_r == 3'd5) begin
            step_r  <= '0;
            term_r  <= T_FIRST;
            ret_r   <= S_TVAL;
            state_r <= S_GO;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_TVAL: begin
          if (step_r == 3'd5) begin
            step_r  <= '0;
            state_r <= S_SEC;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_SEC: begin
          if (step_r == 3'd2) begin
            step_r  <= '0;
            term_r  <= T_SECOND;
            ret_r   <= S_PRD;
            state_r <= S_GO;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_PRD: begin
          if (step_r == 3'd2) begin
            step_r  <= '0;
            term_r  <= T_PROD;
            ret_r   <= S_NEXT;
            state_r <= S_GO;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_GO:    state_r <= S_SCALE;
        S_SCALE: begin
          if (stat.scale_done) begin
            state_r <= ret_r;
          end
        end
        S_NEXT: begin
          if (axis_r == 2'd2) begin
            state_r <= S_FIN;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_QUAD;
          end
        end
        S_FIN: begin
          if (!last_r || !out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_go_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale_go |-> !stat.scale_busy)
    else $error("scaling launched while the unit is busy");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scale_done |-> (state_r == S_SCALE))
    else $error("scaling finished while the controller was not waiting");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrites one that was not taken");
  a_skip_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip_inc |=> (state_r == S_FIN))
    else $error("degenerate face did not go straight to finish");
`endif

endmodule

[src/mesh_volume_integrals.sv]
// ----------------------------------------------------------------------------
// mesh_volume_integrals
// Volume, first and second moments and products of inertia of a closed
// triangle mesh, accumulated one face per request.
// ----------------------------------------------------------------------------
// One triangle is accepted per input request; the request with tlast set
// closes the mesh and produces one result holding the ten integrals (signed
// fixed point with FRAC_BITS fraction bits, saturating) and the count of
// degenerate faces, after which all sums restart from zero. Each face is
// finished before the next one can be taken; a degenerate face ends once
// its normal is known. The time per face is set by the ten scaled terms of
// each face, each passing through the shared scaling unit (launch, two
// partial products, the rounding sum, the divider steps that retire eight
// quotient bits each, and saturation), and by the 60-step program of the
// single multiply-accumulate unit. A finished result waits in the output
// register while the next mesh is accepted; the last face of that next mesh
// holds in its final cycle until the earlier result has been taken.
module mesh_volume_integrals #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z from the lowest bit
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // volume, first_moment_x/y/z, second_moment_x/y/z, product_xy,
  // product_yz, product_zx, skipped_faces from the lowest bit
  output logic [mvi_pkg::OUT_W-1:0]         out_tdata
);
  import mvi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mvi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .stat       (stat)
  );

  mvi_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
